FILE: sv/krt_pkg.sv
// Shared codes and field widths for the keyed record table.
`timescale 1ns / 1ps
package krt_pkg;

	localparam int unsigned KEY_W   = 64;
	localparam int unsigned AGE_W   = 8;
	localparam int unsigned GRADE_W = 32;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned TALLY_W = 5;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_SEARCH = 2'd1;
	localparam op_t OP_REMOVE = 2'd2;
	localparam op_t OP_LIST   = 2'd3;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_MISS = 2'd1;
	localparam status_t ST_FULL = 2'd2;

endpackage

FILE: sv/krt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module krt_ram #(
	parameter int WIDTH = 104,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/keyed_record_table.sv
// Top level of the keyed record table: command sequencer around the record RAM.
`timescale 1ns / 1ps
// Ordered table of up to DEPTH records (key, age, grade) held in one RAM with a
// registered read port. One word is accepted while the sequencer is idle. Insert
// registers its result and goes to S_EMIT. Search and remove walk the stored
// records one per cycle through the single read port (remove compacts in place,
// writing each kept record back as the walk passes it). List emits one word per
// record, reading it through S_LIST_RD, S_LIST_WAIT and S_EMIT in turn. Output
// stall holds the sequencer until the pending word is taken. Keys are stored and
// compared on their low KEY_BITS bits.
module keyed_record_table #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  krt_pkg::op_t                        op,
	input  logic [krt_pkg::KEY_W-1:0]           key,
	input  logic [krt_pkg::AGE_W-1:0]           age,
	input  logic [krt_pkg::GRADE_W-1:0]         grade,
	output logic                                out_valid,
	input  logic                                out_stall,
	output krt_pkg::status_t                    status,
	output logic [krt_pkg::INDEX_W-1:0]         index,
	output logic [krt_pkg::KEY_W-1:0]           found_key,
	output logic [krt_pkg::AGE_W-1:0]           found_age,
	output logic [krt_pkg::GRADE_W-1:0]         found_grade,
	output logic [krt_pkg::TALLY_W-1:0]         tally,
	output logic                                last
);

	import krt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = KEY_BITS + AGE_W + GRADE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LIST_RD,
		S_LIST_WAIT,
		S_EMIT
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        ptr_q;
	logic [CW-1:0]        wr_q;
	logic                 pend_s1;
	logic [CW-1:0]        idx_s1;

	status_t              res_status_q;
	logic [INDEX_W-1:0]   res_index_q;
	logic [KEY_W-1:0]     res_key_q;
	logic [AGE_W-1:0]     res_age_q;
	logic [GRADE_W-1:0]   res_grade_q;
	logic [TALLY_W-1:0]   res_tally_q;
	logic                 res_last_q;

	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [RW-1:0]        ram_wr_data;
	logic                 ram_rd_en;
	logic [RW-1:0]        ram_rd_data;
	logic [KEY_BITS-1:0]  rd_key;
	logic [AGE_W-1:0]     rd_age;
	logic [GRADE_W-1:0]   rd_grade;

	logic                 insert_go;
	logic                 issue;
	logic                 hit;
	logic                 out_free;
	logic                 emit_go;
	logic [CW-1:0]        removed;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;
	assign emit_go  = (state_q == S_EMIT) && out_free;

	assign rd_key   = ram_rd_data[RW-1 -: KEY_BITS];
	assign rd_age   = ram_rd_data[GRADE_W +: AGE_W];
	assign rd_grade = ram_rd_data[GRADE_W-1:0];

	assign insert_go = (state_q == S_IDLE) && in_valid && (op == OP_INSERT)
		&& (n_q != CW'(DEPTH));
	assign issue   = (state_q == S_SCAN) && (ptr_q != n_q);
	assign hit     = (rd_key == key_q);
	assign removed = n_q - wr_q;

	always_comb begin
		ram_rd_en = issue || (state_q == S_LIST_RD);
		if (state_q == S_IDLE) begin
			ram_wr_en   = insert_go;
			ram_wr_addr = n_q[AW-1:0];
			ram_wr_data = {key[KEY_BITS-1:0], age, grade};
		end else begin
			ram_wr_en   = (state_q == S_SCAN) && pend_s1 && (op_q == OP_REMOVE) && !hit;
			ram_wr_addr = wr_q[AW-1:0];
			ram_wr_data = ram_rd_data;
		end
	end

	krt_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ptr_q[AW-1:0]),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			pend_s1   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			pend_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q  <= op;
						key_q <= key[KEY_BITS-1:0];
						ptr_q <= '0;
						wr_q  <= '0;
						res_last_q <= 1'b1;
						unique case (op) inside
							OP_INSERT: begin
								if (insert_go) begin
									res_status_q <= ST_OK;
									res_index_q  <= INDEX_W'(n_q);
									res_key_q    <= KEY_W'(key[KEY_BITS-1:0]);
									res_age_q    <= age;
									res_grade_q  <= grade;
									res_tally_q  <= TALLY_W'(n_q + 1'b1);
									n_q          <= n_q + 1'b1;
								end else begin
									res_status_q <= ST_FULL;
									res_index_q  <= '0;
									res_key_q    <= '0;
									res_age_q    <= '0;
									res_grade_q  <= '0;
									res_tally_q  <= TALLY_W'(n_q);
								end
								state_q <= S_EMIT;
							end
							OP_SEARCH, OP_REMOVE: begin
								state_q <= S_SCAN;
							end
							default: begin
								if (n_q == '0) begin
									res_status_q <= ST_MISS;
									res_index_q  <= '0;
									res_key_q    <= '0;
									res_age_q    <= '0;
									res_grade_q  <= '0;
									res_tally_q  <= '0;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_LIST_RD;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					ptr_q   <= ptr_q + CW'(issue);
					idx_s1  <= ptr_q;
					if (pend_s1) begin
						if (op_q == OP_SEARCH) begin
							if (hit) begin
								res_status_q <= ST_OK;
								res_index_q  <= INDEX_W'(idx_s1);
								res_key_q    <= KEY_W'(rd_key);
								res_age_q    <= rd_age;
								res_grade_q  <= rd_grade;
								res_tally_q  <= TALLY_W'(n_q);
								state_q      <= S_EMIT;
							end
						end else if (!hit) begin
							wr_q <= wr_q + 1'b1;
						end
					end else if (ptr_q == n_q) begin
						res_index_q <= '0;
						res_key_q   <= '0;
						res_age_q   <= '0;
						res_grade_q <= '0;
						if (op_q == OP_SEARCH) begin
							res_status_q <= ST_MISS;
							res_tally_q  <= TALLY_W'(n_q);
						end else begin
							res_status_q <= (removed != '0) ? ST_OK : ST_MISS;
							res_tally_q  <= TALLY_W'(removed);
							n_q          <= wr_q;
						end
						state_q <= S_EMIT;
					end
				end
				S_LIST_RD: begin
					state_q <= S_LIST_WAIT;
				end
				S_LIST_WAIT: begin
					res_status_q <= ST_OK;
					res_index_q  <= INDEX_W'(ptr_q);
					res_key_q    <= KEY_W'(rd_key);
					res_age_q    <= rd_age;
					res_grade_q  <= rd_grade;
					res_tally_q  <= TALLY_W'(n_q);
					res_last_q   <= (ptr_q + 1'b1 == n_q);
					ptr_q        <= ptr_q + 1'b1;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						status      <= res_status_q;
						index       <= res_index_q;
						found_key   <= res_key_q;
						found_age   <= res_age_q;
						found_grade <= res_grade_q;
						tally       <= res_tally_q;
						last        <= res_last_q;
						if ((op_q == OP_LIST) && (ptr_q != n_q)) begin
							state_q <= S_LIST_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && ram_wr_en) |-> (wr_q <= idx_s1))
		else $error("compaction write passed the read index");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (idx_s1 < n_q))
		else $error("read beyond filled entries");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		insert_go |=> (n_q == $past(n_q) + 1'b1))
		else $error("insert did not grow the table");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && op_q != OP_LIST) |-> res_last_q)
		else $error("single-word command without last");

endmodule

FILE: dv/tb_keyed_record_table.sv
// Self-checking testbench for the keyed record table: random stimulus, predictor and scoreboard.
`timescale 1ns / 1ps
module tb_keyed_record_table;
	import krt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int KEY_BITS    = 64;
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

	typedef struct {
		op_t                op;
		logic [KEY_W-1:0]   key;
		logic [AGE_W-1:0]   age;
		logic [GRADE_W-1:0] grade;
		bit                 hold;
	} table_cmd_t;

	typedef struct {
		status_t            status;
		logic [INDEX_W-1:0] index;
		logic [KEY_W-1:0]   key;
		logic [AGE_W-1:0]   age;
		logic [GRADE_W-1:0] grade;
		logic [TALLY_W-1:0] tally;
		logic               last;
	} table_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	op_t op = OP_INSERT;
	logic [KEY_W-1:0] key = '0;
	logic [AGE_W-1:0] age = '0;
	logic [GRADE_W-1:0] grade = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	status_t status;
	logic [INDEX_W-1:0] index;
	logic [KEY_W-1:0] found_key;
	logic [AGE_W-1:0] found_age;
	logic [GRADE_W-1:0] found_grade;
	logic [TALLY_W-1:0] tally;
	logic last;

	table_cmd_t pending_cmds[$];
	table_reply_t predicted_replies[$];

	logic [KEY_W-1:0] tbl_key [TABLE_DEPTH];
	logic [AGE_W-1:0] tbl_age [TABLE_DEPTH];
	logic [GRADE_W-1:0] tbl_grade [TABLE_DEPTH];
	int tbl_count = 0;

	int mismatches = 0;
	int accepted_cmds = 0;
	int total_cmds = 0;
	bit in_took = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_off_left = 0;
	bit hold_off_done = 1'b0;
	int stall_mode = 0;
	int stall_mode_left = 0;

	keyed_record_table #(
		.DEPTH(TABLE_DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.key(key),
		.age(age),
		.grade(grade),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.index(index),
		.found_key(found_key),
		.found_age(found_age),
		.found_grade(found_grade),
		.tally(tally),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void push_reply(status_t s, logic [INDEX_W-1:0] i, logic [KEY_W-1:0] k,
			logic [AGE_W-1:0] a, logic [GRADE_W-1:0] g, logic [TALLY_W-1:0] t, logic l);
		table_reply_t r;
		r.status = s;
		r.index = i;
		r.key = k;
		r.age = a;
		r.grade = g;
		r.tally = t;
		r.last = l;
		predicted_replies.push_back(r);
	endfunction

	function automatic void apply_table_cmd(op_t c_op, logic [KEY_W-1:0] c_key,
			logic [AGE_W-1:0] c_age, logic [GRADE_W-1:0] c_grade);
		logic [KEY_W-1:0] k;
		int n;
		int w;
		bit hit;
		k = c_key & KEY_MASK;
		n = tbl_count;
		w = 0;
		hit = 1'b0;
		case (c_op)
			OP_INSERT: begin
				if (n >= TABLE_DEPTH) begin
					push_reply(ST_FULL, '0, '0, '0, '0, TALLY_W'(n), 1'b1);
				end else begin
					tbl_key[n] = k;
					tbl_age[n] = c_age;
					tbl_grade[n] = c_grade;
					tbl_count = n + 1;
					push_reply(ST_OK, INDEX_W'(n), k, c_age, c_grade, TALLY_W'(n + 1), 1'b1);
				end
			end
			OP_SEARCH: begin
				for (int i = 0; i < n && !hit; i++) begin
					if (tbl_key[i] == k) begin
						hit = 1'b1;
						push_reply(ST_OK, INDEX_W'(i), tbl_key[i], tbl_age[i], tbl_grade[i],
							TALLY_W'(n), 1'b1);
					end
				end
				if (!hit)
					push_reply(ST_MISS, '0, '0, '0, '0, TALLY_W'(n), 1'b1);
			end
			OP_REMOVE: begin
				for (int i = 0; i < n; i++) begin
					if (tbl_key[i] != k) begin
						tbl_key[w] = tbl_key[i];
						tbl_age[w] = tbl_age[i];
						tbl_grade[w] = tbl_grade[i];
						w++;
					end
				end
				tbl_count = w;
				push_reply((n != w) ? ST_OK : ST_MISS, '0, '0, '0, '0, TALLY_W'(n - w), 1'b1);
			end
			default: begin
				if (n == 0)
					push_reply(ST_MISS, '0, '0, '0, '0, '0, 1'b1);
				for (int i = 0; i < n; i++)
					push_reply(ST_OK, INDEX_W'(i), tbl_key[i], tbl_age[i], tbl_grade[i],
						TALLY_W'(n), (i + 1 == n));
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void add_cmd(op_t o, logic [KEY_W-1:0] k, logic [AGE_W-1:0] a,
			logic [GRADE_W-1:0] g, bit h);
		table_cmd_t c;
		c.op = o;
		c.key = k;
		c.age = a;
		c.grade = g;
		c.hold = h;
		pending_cmds.push_back(c);
	endfunction

	// monitor and scoreboard
	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n) begin
			in_took = in_valid && !in_stall;
			if (in_took) begin
				apply_table_cmd(op, key, age, grade);
				accepted_cmds++;
			end
			if (out_valid && !out_stall) begin
				if (predicted_replies.size() == 0) begin
					$error("unexpected result word: status %0d index %0d", status, index);
					mismatches++;
				end else begin
					want = predicted_replies.pop_front();
					check_field("status", 64'(want.status), 64'(status));
					check_field("index", 64'(want.index), 64'(index));
					check_field("found_key", want.key, found_key);
					check_field("found_age", 64'(want.age), 64'(found_age));
					check_field("found_grade", 64'(want.grade), 64'(found_grade));
					check_field("tally", 64'(want.tally), 64'(tally));
					check_field("last", 64'(want.last), 64'(last));
				end
			end
		end
	end

	// command driver: bursts with gaps, stalled word held
	always @(negedge clk) begin
		table_cmd_t c;
		if (arst_n && !(in_valid && !in_took)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_cmds.size() != 0 &&
					!(pending_cmds[0].hold && predicted_replies.size() != 0)) begin
				c = pending_cmds.pop_front();
				in_valid <= 1'b1;
				op <= c.op;
				key <= c.key;
				age <= c.age;
				grade <= c.grade;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall pattern, with one long hold-off
	always @(negedge clk) begin
		if (hold_off_left != 0) begin
			out_stall <= 1'b1;
			hold_off_left--;
		end else if (!hold_off_done && accepted_cmds >= 60) begin
			hold_off_done = 1'b1;
			hold_off_left = 200;
			out_stall <= 1'b1;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_mode_left = $urandom_range(5, 40);
			end else begin
				stall_mode_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	initial begin
		logic [KEY_W-1:0] key_pool [6];
		logic [KEY_W-1:0] name_key;
		logic [KEY_W-1:0] k;
		op_t o;
		int sel;
		int ins_pct;

		name_key = 64'h0000_0065_6369_6c61;
		for (int i = 0; i < 6; i++)
			key_pool[i] = {$urandom, $urandom};

		// empty table, then fill with one key to capacity
		add_cmd(OP_LIST, '0, '0, '0, 1'b0);
		add_cmd(OP_SEARCH, '0, '0, '0, 1'b0);
		add_cmd(OP_REMOVE, '1, '0, '0, 1'b0);
		add_cmd(OP_INSERT, '0, 8'h00, 32'h0000_0000, 1'b0);
		add_cmd(OP_INSERT, '0, 8'hff, 32'hffff_ffff, 1'b0);
		for (int i = 2; i < TABLE_DEPTH; i++)
			add_cmd(OP_INSERT, '0, AGE_W'($urandom), $urandom, 1'b0);
		add_cmd(OP_INSERT, '1, 8'hff, '1, 1'b0);
		add_cmd(OP_SEARCH, '0, '0, '0, 1'b0);
		add_cmd(OP_LIST, '0, '0, '0, 1'b0);
		add_cmd(OP_REMOVE, '0, '0, '0, 1'b0);
		add_cmd(OP_INSERT, '1, 8'h5a, 32'h1234_5678, 1'b0);
		add_cmd(OP_INSERT, name_key, 8'd21, 32'h4049_0fdb, 1'b0);
		add_cmd(OP_INSERT, name_key, 8'd33, 32'hbf80_0000, 1'b0);
		add_cmd(OP_SEARCH, name_key, '0, '0, 1'b0);
		add_cmd(OP_SEARCH, '1, '0, '0, 1'b0);
		add_cmd(OP_REMOVE, '1, '0, '0, 1'b0);
		add_cmd(OP_LIST, '0, '0, '0, 1'b0);

		for (int r = 0; r < 300; r++) begin
			ins_pct = ((r / 50) % 2 == 0) ? 60 : 35;
			sel = $urandom_range(0, 99);
			if (sel < ins_pct)
				o = OP_INSERT;
			else if (sel < ins_pct + 22)
				o = OP_SEARCH;
			else if (sel < ins_pct + 34)
				o = OP_REMOVE;
			else
				o = OP_LIST;
			if ($urandom_range(0, 4) == 0)
				k = {$urandom, $urandom};
			else
				k = key_pool[$urandom_range(0, 5)];
			add_cmd(o, k, AGE_W'($urandom), $urandom, (r % 75 == 0));
		end
		total_cmds = pending_cmds.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_cmds != total_cmds)
			@(posedge clk);
		while (predicted_replies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
sv/krt_pkg.sv
sv/krt_ram.sv
sv/keyed_record_table.sv
dv/tb_keyed_record_table.sv
